/* rtl/ardma_pkg.sv */
// Shared types and constants of the aux RAM DMA register block.
`timescale 1ns / 1ps
`default_nettype none
package ardma_pkg;

  // Access width codes
  localparam logic [1:0] WIDTH_BYTE = 2'd0;
  localparam logic [1:0] WIDTH_HALF = 2'd1;
  localparam logic [1:0] WIDTH_WORD = 2'd2;

  // Kind of result carried by the read stage
  localparam logic [1:0] KIND_WRITE     = 2'd0;
  localparam logic [1:0] KIND_HALF_READ = 2'd1;
  localparam logic [1:0] KIND_WORD_READ = 2'd2;
  localparam logic [1:0] KIND_BAD       = 2'd3;

  // Byte offsets within the block
  localparam logic [5:0] MODE_OFFSET   = 6'h16;
  localparam logic [5:0] CNT_HI_OFFSET = 6'h28;
  localparam logic [5:0] CNT_LO_OFFSET = 6'h2A;

  // Halfword slot of main-address high; six DMA halfwords follow in order
  localparam int DMA_SLOT_BASE = 16;
  localparam int DMA_SLOTS     = 6;

  localparam logic [31:0] MAIN_MASK  = 32'h01FF_FFFF;
  localparam logic [31:0] MAIN_LIMIT = 32'h0180_0000;
  localparam logic [31:0] LEN_MASK   = 32'h7FFF_FFFF;

  typedef struct packed {
    logic        start;
    logic        to_main;
    logic [24:0] main_offset;
    logic [23:0] aux_offset;
    logic [30:0] length;
    logic        range_error;
  } ardma_cmd_t;

endpackage
`default_nettype wire

/* rtl/ardma_ram.sv */
// Generic single-port RAM with enabled, registered read.
`timescale 1ns / 1ps
`default_nettype none
module ardma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

/* rtl/ardma_cmd.sv */
// Transfer command builder: masks addresses, checks ranges, splits the count.
`timescale 1ns / 1ps
`default_nettype none
module ardma_cmd #(
  parameter int AUX_ADDR_BITS = 24
) (
  input  wire logic [31:0]          main_addr,
  input  wire logic [31:0]          aux_addr,
  input  wire logic [31:0]          count,
  output ardma_pkg::ardma_cmd_t     cmd
);
  import ardma_pkg::*;

  localparam logic [31:0] AUX_SIZE = 32'(64'(1) << AUX_ADDR_BITS);
  localparam logic [31:0] AUX_MASK = AUX_SIZE - 32'd1;

  logic [31:0] len;
  logic [31:0] main_off;
  logic [31:0] aux_off;
  logic [31:0] main_end;
  logic [31:0] aux_end;
  logic        bad;

  always_comb begin
    len      = count & LEN_MASK;
    main_off = main_addr & MAIN_MASK;
    aux_off  = aux_addr & AUX_MASK;
    main_end = main_off + len;
    aux_end  = aux_off + len;
    bad      = (main_end > MAIN_LIMIT) || (aux_end > AUX_SIZE);
    cmd      = '0;
    // a zero length starts nothing and raises nothing
    if (len != 32'd0) begin
      cmd.start       = !bad;
      cmd.to_main     = count[31];
      cmd.main_offset = main_off[24:0];
      cmd.aux_offset  = aux_off[23:0];
      cmd.length      = len[30:0];
      cmd.range_error = bad;
    end
  end

endmodule
`default_nettype wire

/* rtl/aux_ram_dma_register_block_top.sv */
// Top level: halfword register file with DMA command issue.
// A result passes through the read stage and then the output register.
// One word per cycle while out_ready does not stall the output; the register file sits in two RAM banks
// (even and odd halfwords) so a word access reads or writes both halves at once.
// Reset clears the per-halfword valid bits, the DMA register copies and the
// pipeline valids; unwritten halfwords read as zero, so no clearing pass runs.
`timescale 1ns / 1ps
`default_nettype none
module aux_ram_dma_register_block_top #(
  parameter int AUX_ADDR_BITS = 24,
  parameter int REG_COUNT     = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        mode,
  input  wire logic [1:0]  access_width,
  input  wire logic [5:0]  reg_offset,
  input  wire logic [31:0] write_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      read_data,
  output logic             bad_access,
  output logic             dma_start,
  output logic             dma_to_main,
  output logic [24:0]      dma_main_offset,
  output logic [23:0]      dma_aux_offset,
  output logic [30:0]      dma_length,
  output logic             dma_range_error
);
  import ardma_pkg::*;

  // Offsets reach slot 32 at most, so only that many slots are ever used
  localparam int SLOTS      = (REG_COUNT < 33) ? REG_COUNT : 33;
  localparam int EVEN_DEPTH = (SLOTS + 1) / 2;
  localparam int ODD_DEPTH  = SLOTS / 2;
  localparam int EA_W       = $clog2(EVEN_DEPTH);
  localparam int OA_W       = $clog2(ODD_DEPTH);
  localparam int VI_W       = $clog2(SLOTS);

  logic             accept;
  logic             is_half;
  logic             is_word;
  logic             is_write;
  logic             is_read;
  logic [5:0]       slot_a;
  logic [5:0]       slot_b_raw;
  logic [5:0]       slot_b;
  logic             a_odd;
  logic [15:0]      data_a;
  logic [15:0]      data_b;

  logic             even_we, odd_we, even_re, odd_re;
  logic [EA_W-1:0]  even_addr;
  logic [OA_W-1:0]  odd_addr;
  logic [15:0]      even_wdata, odd_wdata, even_q, odd_q;

  logic [SLOTS-1:0] valid_bits;
  logic [15:0]      dma_regs [DMA_SLOTS];

  logic             s1_valid;
  logic [1:0]       s1_kind;
  logic             s1_a_odd;
  logic             s1_a_vld;
  logic             s1_b_vld;
  logic             s1_force;
  logic             s1_launch;
  logic             s1_move;

  logic [15:0]      hi_half, lo_half;
  logic [31:0]      read_next;
  ardma_cmd_t       cmd;

  always_comb begin
    is_half    = (access_width == WIDTH_HALF);
    is_word    = (access_width == WIDTH_WORD);
    is_write   = mode && (is_half || is_word);
    is_read    = !mode && (is_half || is_word);
    slot_a     = {1'b0, reg_offset[5:1]};
    slot_b_raw = slot_a + 6'd1;
    slot_b     = (slot_b_raw == 6'(REG_COUNT)) ? 6'd0 : slot_b_raw;
    a_odd      = slot_a[0];
    // a halfword write lands in slot a; a word puts its high half in a
    data_a     = is_half ? write_value[15:0] : write_value[31:16];
    data_b     = write_value[15:0];
  end

  assign s1_move  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_move;
  assign accept   = in_valid && in_ready;

  // Slot a and slot b fall in opposite banks, except when an odd REG_COUNT wraps slot b to 0
  always_comb begin
    even_addr  = a_odd ? slot_b[EA_W:1] : slot_a[EA_W:1];
    odd_addr   = a_odd ? slot_a[OA_W:1] : slot_b[OA_W:1];
    even_wdata = a_odd ? data_b : data_a;
    odd_wdata  = a_odd ? data_a : data_b;
    even_we    = accept && is_write && (is_word || !a_odd);
    odd_we     = accept && is_write && (is_word || a_odd);
    even_re    = accept && is_read && (is_word || !a_odd);
    odd_re     = accept && is_read && (is_word || a_odd);
  end

  ardma_ram #(
    .WIDTH (16),
    .DEPTH (EVEN_DEPTH)
  ) u_even_bank (
    .clk   (clk),
    .we    (even_we),
    .re    (even_re),
    .addr  (even_addr),
    .wdata (even_wdata),
    .rdata (even_q)
  );

  ardma_ram #(
    .WIDTH (16),
    .DEPTH (ODD_DEPTH)
  ) u_odd_bank (
    .clk   (clk),
    .we    (odd_we),
    .re    (odd_re),
    .addr  (odd_addr),
    .wdata (odd_wdata),
    .rdata (odd_q)
  );

  // Valid bits and the copies of the six DMA halfwords
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      for (int i = 0; i < DMA_SLOTS; i++) begin
        dma_regs[i] <= '0;
      end
    end else if (accept && is_write) begin
      valid_bits[slot_a[VI_W-1:0]] <= 1'b1;
      if (is_word) begin
        valid_bits[slot_b[VI_W-1:0]] <= 1'b1;
      end
      for (int i = 0; i < DMA_SLOTS; i++) begin
        if (slot_a == 6'(DMA_SLOT_BASE + i)) begin
          dma_regs[i] <= data_a;
        end else if (is_word && slot_b == 6'(DMA_SLOT_BASE + i)) begin
          dma_regs[i] <= data_b;
        end
      end
    end
  end

  // Read stage: RAM data arrives alongside the item
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (!(is_half || is_word)) begin
        s1_kind <= KIND_BAD;
      end else if (mode) begin
        s1_kind <= KIND_WRITE;
      end else if (is_half) begin
        s1_kind <= KIND_HALF_READ;
      end else begin
        s1_kind <= KIND_WORD_READ;
      end
      s1_a_odd  <= a_odd;
      s1_a_vld  <= valid_bits[slot_a[VI_W-1:0]];
      s1_b_vld  <= valid_bits[slot_b[VI_W-1:0]];
      s1_force  <= is_half && (reg_offset[5:1] == MODE_OFFSET[5:1]);
      s1_launch <= mode && ((is_half && reg_offset[5:1] == CNT_LO_OFFSET[5:1]) ||
                            (is_word && reg_offset == CNT_HI_OFFSET));
    end
  end

  ardma_cmd #(
    .AUX_ADDR_BITS (AUX_ADDR_BITS)
  ) u_cmd (
    .main_addr ({dma_regs[0], dma_regs[1]}),
    .aux_addr  ({dma_regs[2], dma_regs[3]}),
    .count     ({dma_regs[4], dma_regs[5]}),
    .cmd       (cmd)
  );

  always_comb begin
    hi_half = s1_a_odd ? odd_q : even_q;
    lo_half = s1_a_odd ? even_q : odd_q;
    // never-written halfwords read as zero
    if (!s1_a_vld) begin
      hi_half = '0;
    end
    if (!s1_b_vld) begin
      lo_half = '0;
    end
    case (s1_kind)
      KIND_HALF_READ: read_next = {16'd0, hi_half[15:1], hi_half[0] | s1_force};
      KIND_WORD_READ: read_next = {hi_half, lo_half};
      default:        read_next = '0;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      read_data       <= read_next;
      bad_access      <= (s1_kind == KIND_BAD);
      dma_start       <= s1_launch && cmd.start;
      dma_to_main     <= s1_launch && cmd.to_main;
      dma_main_offset <= s1_launch ? cmd.main_offset : '0;
      dma_aux_offset  <= s1_launch ? cmd.aux_offset : '0;
      dma_length      <= s1_launch ? cmd.length : '0;
      dma_range_error <= s1_launch && cmd.range_error;
    end
  end

endmodule
`default_nettype wire
